/* rtl/snfcp_pkg.sv */
package snfcp_pkg;

   // Screen size in pixels
   localparam int SCREEN_WIDTH  = 900;
   localparam int SCREEN_HEIGHT = 600;

   // Clip planes, signed Q16.16 (0.2 and 500.0)
   localparam logic signed [31:0] NEAR_Q = 32'sd13107;
   localparam logic signed [31:0] FAR_Q  = 32'sd32768000;

   // Interpolation factor is unsigned Q1.24 (quotient bits Q0.24)
   localparam int T_BITS = 24;
   localparam logic [T_BITS:0] T_ONE = (T_BITS + 1)'(1) << T_BITS;

   // Pixel quotient magnitude bits, below the saturation point
   localparam int Q_BITS = 15;

   // Depth scale terms of the projection numerators
   localparam longint W_SCALE = longint'(SCREEN_WIDTH) * 4096;
   localparam longint H_SCALE = longint'(SCREEN_HEIGHT) * 4096;

   // Port widths
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 72;

   // Pipeline stage map
   localparam int ST_DIFF  = 0;
   localparam int ST_YAW   = ST_DIFF + 1;
   localparam int ST_PITCH = ST_YAW + 1;
   localparam int ST_NEAR  = ST_PITCH + 1;
   localparam int ST_FAR   = ST_NEAR + 1;
   localparam int ST_TDIV  = ST_FAR + 1;
   localparam int ST_L1D   = ST_TDIV + T_BITS;
   localparam int ST_L1M   = ST_L1D + 1;
   localparam int ST_L2D   = ST_L1M + 1;
   localparam int ST_L2M   = ST_L2D + 1;
   localparam int ST_P1    = ST_L2M + 1;
   localparam int ST_P2    = ST_P1 + 1;
   localparam int ST_P3    = ST_P2 + 1;
   localparam int ST_SDIV  = ST_P3 + 1;
   localparam int ST_OUT   = ST_SDIV + Q_BITS;
   localparam int NSTAGE   = ST_OUT + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAMERA_X   = 3'd0,
      CSR_CAMERA_Y   = 3'd1,
      CSR_CAMERA_Z   = 3'd2,
      CSR_COS_YAW    = 3'd3,
      CSR_SIN_YAW    = 3'd4,
      CSR_COS_PITCH  = 3'd5,
      CSR_SIN_PITCH  = 3'd6,
      CSR_PROJ_SCALE = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [31:0] camera_x;
      logic signed [31:0] camera_y;
      logic signed [31:0] camera_z;
      logic signed [15:0] cos_yaw;
      logic signed [15:0] sin_yaw;
      logic signed [15:0] cos_pitch;
      logic signed [15:0] sin_pitch;
      logic [15:0]        proj_scale;
   } cfg_type;

   // Point during rotation, before saturation
   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] z;
   } raw3_type;

   // Camera space point, Q16.16
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } cam3_type;

   // Per endpoint projection work
   typedef struct packed {
      logic [30:0]        zc;
      logic signed [47:0] mx;
      logic signed [47:0] my;
      logic signed [56:0] zw;
      logic signed [56:0] zh;
      logic signed [61:0] nx;
      logic signed [61:0] ny;
      logic               x_neg;
      logic               y_neg;
      logic               x_ovf;
      logic               y_ovf;
      logic [47:0]        remx;
      logic [47:0]        remy;
      logic [Q_BITS-1:0]  qx;
      logic [Q_BITS-1:0]  qy;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
   } prj_type;

   // Everything one segment carries down the pipeline
   typedef struct packed {
      raw3_type           ra;
      raw3_type           rb;
      cam3_type           a;
      cam3_type           b;
      logic               rej0;
      logic               near_a;
      logic               near_b;
      logic               far_a;
      logic               far_b;
      logic               vis;
      logic [31:0]        num1;
      logic [31:0]        den1;
      logic [31:0]        num2;
      logic [31:0]        den2;
      logic               one1;
      logic               one2;
      logic [31:0]        rem1;
      logic [31:0]        rem2;
      logic [T_BITS-1:0]  q1;
      logic [T_BITS-1:0]  q2;
      logic [T_BITS:0]    t1;
      logic [T_BITS:0]    t2;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      prj_type            pa;
      prj_type            pb;
   } seg_type;

   localparam logic signed [38:0] S32_MAX = 39'sd2147483647;
   localparam logic signed [38:0] S32_MIN = -39'sd2147483648;

   function automatic logic signed [31:0] sat32(logic signed [38:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) r = 32'sh7fffffff;
      else if (v < S32_MIN) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic raw3_type rot_yaw(raw3_type p, cfg_type c);
      raw3_type r;
      logic signed [49:0] sx;
      logic signed [49:0] sz;
      sx = 50'(p.x) * 50'(c.cos_yaw) + 50'(p.z) * 50'(c.sin_yaw);
      sz = 50'(p.z) * 50'(c.cos_yaw) - 50'(p.x) * 50'(c.sin_yaw);
      r.x = 36'(sx >>> 14);
      r.y = p.y;
      r.z = 36'(sz >>> 14);
      return r;
   endfunction

   function automatic cam3_type rot_pitch(raw3_type p, cfg_type c);
      cam3_type r;
      logic signed [52:0] sy;
      logic signed [52:0] sz;
      sy = 53'(p.y) * 53'(c.cos_pitch) - 53'(p.z) * 53'(c.sin_pitch);
      sz = 53'(p.y) * 53'(c.sin_pitch) + 53'(p.z) * 53'(c.cos_pitch);
      r.x = sat32(39'(p.x));
      r.y = sat32(39'(sy >>> 14));
      r.z = sat32(39'(sz >>> 14));
      return r;
   endfunction

   function automatic seg_type st_diff(logic [REQ_DATA_W-1:0] d, cfg_type c);
      seg_type s;
      s = '0;
      s.ra.x = 36'(signed'(d[31:0]))    - 36'(c.camera_x);
      s.ra.y = 36'(signed'(d[63:32]))   - 36'(c.camera_y);
      s.ra.z = 36'(signed'(d[95:64]))   - 36'(c.camera_z);
      s.rb.x = 36'(signed'(d[127:96]))  - 36'(c.camera_x);
      s.rb.y = 36'(signed'(d[159:128])) - 36'(c.camera_y);
      s.rb.z = 36'(signed'(d[191:160])) - 36'(c.camera_z);
      return s;
   endfunction

   // Near plane: reject test, pick the end to move, set up its factor
   function automatic seg_type st_near(seg_type s);
      seg_type r;
      logic signed [31:0] az;
      logic signed [31:0] bz;
      r = s;
      az = s.a.z;
      bz = s.b.z;
      r.rej0 = (az <= NEAR_Q && bz <= NEAR_Q) || (az >= FAR_Q && bz >= FAR_Q);
      r.near_a = (az < NEAR_Q) && (bz > az);
      r.near_b = !r.near_a && (bz < NEAR_Q) && (az > bz);
      r.num1 = 32'd0;
      r.den1 = 32'd1;
      if (r.near_a) begin
         r.num1 = 32'(33'(NEAR_Q) - 33'(az));
         r.den1 = 32'(33'(bz) - 33'(az));
         r.a.z = NEAR_Q;
      end else if (r.near_b) begin
         r.num1 = 32'(33'(az) - 33'(NEAR_Q));
         r.den1 = 32'(33'(az) - 33'(bz));
         r.b.z = NEAR_Q;
      end
      return r;
   endfunction

   // Far plane on the near-clipped depths, final reject, divider start
   function automatic seg_type st_far(seg_type s);
      seg_type r;
      logic signed [31:0] az;
      logic signed [31:0] bz;
      logic rej2;
      r = s;
      az = s.a.z;
      bz = s.b.z;
      r.far_a = (az > FAR_Q) && (bz < az);
      r.far_b = !r.far_a && (bz > FAR_Q) && (az < bz);
      r.num2 = 32'd0;
      r.den2 = 32'd1;
      if (r.far_a) begin
         r.num2 = 32'(33'(az) - 33'(FAR_Q));
         r.den2 = 32'(33'(az) - 33'(bz));
         r.a.z = FAR_Q;
      end else if (r.far_b) begin
         r.num2 = 32'(33'(FAR_Q) - 33'(az));
         r.den2 = 32'(33'(bz) - 33'(az));
         r.b.z = FAR_Q;
      end
      rej2 = (r.a.z <= NEAR_Q && r.b.z <= NEAR_Q) || (r.a.z >= FAR_Q && r.b.z >= FAR_Q);
      r.vis = !s.rej0 && !rej2;
      r.one1 = r.num1 >= r.den1;
      r.one2 = r.num2 >= r.den2;
      r.rem1 = r.one1 ? 32'd0 : r.num1;
      r.rem2 = r.one2 ? 32'd0 : r.num2;
      r.q1 = '0;
      r.q2 = '0;
      return r;
   endfunction

   // One restoring quotient bit for both factors
   function automatic seg_type st_tdiv(seg_type s);
      seg_type r;
      logic [32:0] w1;
      logic [32:0] w2;
      r = s;
      w1 = {s.rem1, 1'b0};
      w2 = {s.rem2, 1'b0};
      if (w1 >= {1'b0, s.den1}) begin
         w1 = w1 - {1'b0, s.den1};
         r.q1 = {s.q1[T_BITS-2:0], 1'b1};
      end else begin
         r.q1 = {s.q1[T_BITS-2:0], 1'b0};
      end
      if (w2 >= {1'b0, s.den2}) begin
         w2 = w2 - {1'b0, s.den2};
         r.q2 = {s.q2[T_BITS-2:0], 1'b1};
      end else begin
         r.q2 = {s.q2[T_BITS-2:0], 1'b0};
      end
      r.rem1 = w1[31:0];
      r.rem2 = w2[31:0];
      return r;
   endfunction

   function automatic seg_type st_ldiff(seg_type s);
      seg_type r;
      r = s;
      r.t1 = s.one1 ? T_ONE : {1'b0, s.q1};
      r.t2 = s.one2 ? T_ONE : {1'b0, s.q2};
      r.dx = 33'(s.b.x) - 33'(s.a.x);
      r.dy = 33'(s.b.y) - 33'(s.a.y);
      return r;
   endfunction

   function automatic logic signed [31:0] lerp(logic signed [31:0] base,
                                               logic signed [32:0] d,
                                               logic [T_BITS:0] t);
      logic signed [58:0] p;
      p = 59'(d) * 59'(signed'({1'b0, t}));
      return 32'(35'(base) + 35'(p >>> T_BITS));
   endfunction

   function automatic seg_type st_lmul1(seg_type s);
      seg_type r;
      r = s;
      if (s.near_a) begin
         r.a.x = lerp(s.a.x, s.dx, s.t1);
         r.a.y = lerp(s.a.y, s.dy, s.t1);
      end else if (s.near_b) begin
         r.b.x = lerp(s.a.x, s.dx, s.t1);
         r.b.y = lerp(s.a.y, s.dy, s.t1);
      end
      return r;
   endfunction

   function automatic seg_type st_lmul2(seg_type s);
      seg_type r;
      r = s;
      if (s.far_a) begin
         r.a.x = lerp(s.a.x, s.dx, s.t2);
         r.a.y = lerp(s.a.y, s.dy, s.t2);
      end else if (s.far_b) begin
         r.b.x = lerp(s.a.x, s.dx, s.t2);
         r.b.y = lerp(s.a.y, s.dy, s.t2);
      end
      return r;
   endfunction

   function automatic prj_type prj_p1(prj_type q, cam3_type p, cfg_type c);
      prj_type r;
      r = q;
      r.zc = (p.z < 32'sd1) ? 31'd1 : p.z[30:0];
      r.mx = 48'(p.x) * 48'(signed'({1'b0, c.proj_scale}));
      r.my = 48'(p.y) * 48'(signed'({1'b0, c.proj_scale}));
      r.zw = 57'(57'(r.zc) * 57'(W_SCALE));
      r.zh = 57'(57'(r.zc) * 57'(H_SCALE));
      return r;
   endfunction

   function automatic prj_type prj_p2(prj_type q);
      prj_type r;
      r = q;
      r.nx = 62'(q.zw) + 62'(q.mx) * 62'(SCREEN_HEIGHT);
      r.ny = 62'(q.zh) - 62'(q.my) * 62'(SCREEN_HEIGHT);
      return r;
   endfunction

   // Magnitudes over 8192, and the saturation test against the depth
   function automatic prj_type prj_p3(prj_type q);
      prj_type r;
      logic [61:0] mx;
      logic [61:0] my;
      r = q;
      mx = q.nx[61] ? 62'(-q.nx) : 62'(q.nx);
      my = q.ny[61] ? 62'(-q.ny) : 62'(q.ny);
      r.x_neg = q.nx[61];
      r.y_neg = q.ny[61];
      r.remx = 48'(mx >> 13);
      r.remy = 48'(my >> 13);
      r.x_ovf = r.remx >= (48'(q.zc) << Q_BITS);
      r.y_ovf = r.remy >= (48'(q.zc) << Q_BITS);
      r.qx = '0;
      r.qy = '0;
      return r;
   endfunction

   function automatic prj_type prj_div(prj_type q, int sh);
      prj_type r;
      logic [47:0] dv;
      r = q;
      dv = 48'(q.zc) << sh;
      if (q.remx >= dv) begin
         r.remx = q.remx - dv;
         r.qx = {q.qx[Q_BITS-2:0], 1'b1};
      end else begin
         r.qx = {q.qx[Q_BITS-2:0], 1'b0};
      end
      if (q.remy >= dv) begin
         r.remy = q.remy - dv;
         r.qy = {q.qy[Q_BITS-2:0], 1'b1};
      end else begin
         r.qy = {q.qy[Q_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic signed [15:0] pix(logic [Q_BITS-1:0] q, logic neg, logic ovf);
      logic signed [15:0] v;
      if (ovf) v = neg ? 16'sh8000 : 16'sh7fff;
      else if (neg) v = -signed'({1'b0, q});
      else v = signed'({1'b0, q});
      return v;
   endfunction

   function automatic prj_type prj_out(prj_type q, logic vis);
      prj_type r;
      r = q;
      r.sx = vis ? pix(q.qx, q.x_neg, q.x_ovf) : 16'sd0;
      r.sy = vis ? pix(q.qy, q.y_neg, q.y_ovf) : 16'sd0;
      return r;
   endfunction

endpackage

/* rtl/segment_near_far_clip_project_unit.sv */
// Channel  Dir  Fields (lowest bit first)
// req_     in   start_x, start_y, start_z, end_x, end_y, end_z (32 bit each)
// rsp_     out  visible, start_sx, start_sy, end_sx, end_sy, zero pad to 72
// csr_     in   write enable, register index, 32 bit data
//
// One segment per cycle while the output is not stalled.
// The depth is set by the two restoring dividers: 24 stages for the clip factor
// and 15 stages for the perspective divide, one quotient bit per stage.
// Reset clears the valid bits and loads the camera registers; no clearing pass.
// Each stage holds while the stage after it is full and held, so a stalled
// output still lets empty stages upstream fill.
module segment_near_far_clip_project_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [snfcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [snfcp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z
   input  logic [snfcp_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // visible, start_sx, start_sy, end_sx, end_sy, pad
   output logic [snfcp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import snfcp_pkg::*;

   cfg_type              cfg_ff;
   seg_type              seg_ff [NSTAGE];
   seg_type              seg_in [NSTAGE];
   logic [NSTAGE-1:0]    vld_ff;
   logic [NSTAGE-1:0]    vld_src;
   logic [NSTAGE:0]      adv;
   seg_type              last;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_x   <= 32'sd327680;
         cfg_ff.camera_y   <= 32'sd0;
         cfg_ff.camera_z   <= -32'sd655360;
         cfg_ff.cos_yaw    <= 16'sd16384;
         cfg_ff.sin_yaw    <= 16'sd0;
         cfg_ff.cos_pitch  <= 16'sd16384;
         cfg_ff.sin_pitch  <= 16'sd0;
         cfg_ff.proj_scale <= 16'd4096;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CAMERA_X:   cfg_ff.camera_x   <= csr_wdata;
            CSR_CAMERA_Y:   cfg_ff.camera_y   <= csr_wdata;
            CSR_CAMERA_Z:   cfg_ff.camera_z   <= csr_wdata;
            CSR_COS_YAW:    cfg_ff.cos_yaw    <= csr_wdata[15:0];
            CSR_SIN_YAW:    cfg_ff.sin_yaw    <= csr_wdata[15:0];
            CSR_COS_PITCH:  cfg_ff.cos_pitch  <= csr_wdata[15:0];
            CSR_SIN_PITCH:  cfg_ff.sin_pitch  <= csr_wdata[15:0];
            CSR_PROJ_SCALE: cfg_ff.proj_scale <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      adv[NSTAGE] = rsp_tready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign vld_src = {vld_ff[NSTAGE-2:0], req_tvalid};

   // Stage logic
   always_comb begin
      seg_in[ST_DIFF] = st_diff(req_tdata, cfg_ff);

      seg_in[ST_YAW]    = seg_ff[ST_DIFF];
      seg_in[ST_YAW].ra = rot_yaw(seg_ff[ST_DIFF].ra, cfg_ff);
      seg_in[ST_YAW].rb = rot_yaw(seg_ff[ST_DIFF].rb, cfg_ff);

      seg_in[ST_PITCH]   = seg_ff[ST_YAW];
      seg_in[ST_PITCH].a = rot_pitch(seg_ff[ST_YAW].ra, cfg_ff);
      seg_in[ST_PITCH].b = rot_pitch(seg_ff[ST_YAW].rb, cfg_ff);

      seg_in[ST_NEAR] = st_near(seg_ff[ST_PITCH]);
      seg_in[ST_FAR]  = st_far(seg_ff[ST_NEAR]);

      seg_in[ST_TDIV] = st_tdiv(seg_ff[ST_FAR]);
      for (int k = 1; k < T_BITS; k++) begin
         seg_in[ST_TDIV+k] = st_tdiv(seg_ff[ST_TDIV+k-1]);
      end

      seg_in[ST_L1D] = st_ldiff(seg_ff[ST_L1D-1]);
      seg_in[ST_L1M] = st_lmul1(seg_ff[ST_L1D]);
      seg_in[ST_L2D] = st_ldiff(seg_ff[ST_L1M]);
      seg_in[ST_L2M] = st_lmul2(seg_ff[ST_L2D]);

      seg_in[ST_P1]    = seg_ff[ST_L2M];
      seg_in[ST_P1].pa = prj_p1(seg_ff[ST_L2M].pa, seg_ff[ST_L2M].a, cfg_ff);
      seg_in[ST_P1].pb = prj_p1(seg_ff[ST_L2M].pb, seg_ff[ST_L2M].b, cfg_ff);

      seg_in[ST_P2]    = seg_ff[ST_P1];
      seg_in[ST_P2].pa = prj_p2(seg_ff[ST_P1].pa);
      seg_in[ST_P2].pb = prj_p2(seg_ff[ST_P1].pb);

      seg_in[ST_P3]    = seg_ff[ST_P2];
      seg_in[ST_P3].pa = prj_p3(seg_ff[ST_P2].pa);
      seg_in[ST_P3].pb = prj_p3(seg_ff[ST_P2].pb);

      for (int k = 0; k < Q_BITS; k++) begin
         seg_in[ST_SDIV+k]    = seg_ff[ST_SDIV+k-1];
         seg_in[ST_SDIV+k].pa = prj_div(seg_ff[ST_SDIV+k-1].pa, Q_BITS - 1 - k);
         seg_in[ST_SDIV+k].pb = prj_div(seg_ff[ST_SDIV+k-1].pb, Q_BITS - 1 - k);
      end

      seg_in[ST_OUT]    = seg_ff[ST_OUT-1];
      seg_in[ST_OUT].pa = prj_out(seg_ff[ST_OUT-1].pa, seg_ff[ST_OUT-1].vis);
      seg_in[ST_OUT].pb = prj_out(seg_ff[ST_OUT-1].pb, seg_ff[ST_OUT-1].vis);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) vld_ff[k] <= vld_src[k];
         end
      end
   end

   // Stage payload, held while stalled
   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTAGE; k++) begin
         if (adv[k]) seg_ff[k] <= seg_in[k];
      end
   end

   assign last       = seg_ff[NSTAGE-1];
   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NSTAGE-1];
   assign rsp_tdata  = {7'd0, last.pb.sy, last.pb.sx, last.pa.sy, last.pa.sx, last.vis};

endmodule

/* sim/segment_clip_checker.sv */
module segment_clip_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [snfcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [snfcp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [snfcp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [snfcp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                               fail_count,
   output int                               pending
);
   import snfcp_pkg::*;

   localparam longint NEAR_PL = 13107;
   localparam longint FAR_PL  = 32768000;

   typedef struct {
      longint x;
      longint y;
      longint z;
   } vec3_t;

   typedef struct packed {
      logic signed [15:0] end_sy;
      logic signed [15:0] end_sx;
      logic signed [15:0] start_sy;
      logic signed [15:0] start_sx;
      logic               visible;
   } pixel_pair_t;

   logic signed [31:0] cam_x, cam_y, cam_z;
   logic signed [15:0] cyaw, syaw, cpitch, spitch;
   logic [15:0]        pscale;
   pixel_pair_t        pixel_queue[$];

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic vec3_t world_to_camera(logic signed [31:0] wx, logic signed [31:0] wy,
                                             logic signed [31:0] wz);
      vec3_t r;
      longint px, py, pz, tx, tz;
      px = longint'(wx) - longint'(cam_x);
      py = longint'(wy) - longint'(cam_y);
      pz = longint'(wz) - longint'(cam_z);
      tx = floor_shift(px * cyaw + pz * syaw, 14);
      tz = floor_shift(pz * cyaw - px * syaw, 14);
      r.x = clamp(tx, -64'sd2147483648, 64'sd2147483647);
      r.y = clamp(floor_shift(py * cpitch - tz * spitch, 14), -64'sd2147483648,
                  64'sd2147483647);
      r.z = clamp(floor_shift(py * spitch + tz * cpitch, 14), -64'sd2147483648,
                  64'sd2147483647);
      return r;
   endfunction

   function automatic longint clip_factor(longint num, longint den);
      if (den <= 0 || num <= 0) return 0;
      if (num >= den) return longint'(1) << 24;
      return (num << 24) / den;
   endfunction

   function automatic vec3_t slide_to_plane(vec3_t p0, vec3_t p1, longint t, longint plane);
      vec3_t r;
      r.x = p0.x + floor_shift((p1.x - p0.x) * t, 24);
      r.y = p0.y + floor_shift((p1.y - p0.y) * t, 24);
      r.z = plane;
      return r;
   endfunction

   function automatic logic outside_both(vec3_t a, vec3_t b);
      return (a.z <= NEAR_PL && b.z <= NEAR_PL) || (a.z >= FAR_PL && b.z >= FAR_PL);
   endfunction

   function automatic void to_pixel(vec3_t p, output logic signed [15:0] sx,
                                    output logic signed [15:0] sy);
      longint z, den, nx, ny;
      z = p.z < 1 ? 1 : p.z;
      den = z * 8192;
      nx = longint'(SCREEN_WIDTH) * 4096 * z + p.x * longint'(pscale) * SCREEN_HEIGHT;
      ny = longint'(SCREEN_HEIGHT) * 4096 * z - p.y * longint'(pscale) * SCREEN_HEIGHT;
      sx = 16'(clamp(nx / den, -32768, 32767));
      sy = 16'(clamp(ny / den, -32768, 32767));
   endfunction

   function automatic pixel_pair_t project_segment(logic [REQ_DATA_W-1:0] d);
      pixel_pair_t r;
      vec3_t a, b;
      a = world_to_camera(d[31:0], d[63:32], d[95:64]);
      b = world_to_camera(d[127:96], d[159:128], d[191:160]);
      r = '0;
      if (outside_both(a, b)) return r;
      // pull an end forward onto the near plane
      if (a.z < NEAR_PL && b.z > a.z)
         a = slide_to_plane(a, b, clip_factor(NEAR_PL - a.z, b.z - a.z), NEAR_PL);
      else if (b.z < NEAR_PL && a.z > b.z)
         b = slide_to_plane(a, b, clip_factor(a.z - NEAR_PL, a.z - b.z), NEAR_PL);
      // pull an end back onto the far plane
      if (a.z > FAR_PL && b.z < a.z)
         a = slide_to_plane(a, b, clip_factor(a.z - FAR_PL, a.z - b.z), FAR_PL);
      else if (b.z > FAR_PL && a.z < b.z)
         b = slide_to_plane(a, b, clip_factor(FAR_PL - a.z, b.z - a.z), FAR_PL);
      if (outside_both(a, b)) return r;
      r.visible = 1'b1;
      to_pixel(a, r.start_sx, r.start_sy);
      to_pixel(b, r.end_sx, r.end_sy);
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_pair_t got, want;
      if (reset) begin
         cam_x <= 32'sd327680; cam_y <= 32'sd0; cam_z <= -32'sd655360;
         cyaw <= 16'sd16384; syaw <= 16'sd0; cpitch <= 16'sd16384; spitch <= 16'sd0;
         pscale <= 16'd4096;
         pixel_queue.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         // mirror register writes
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_CAMERA_X:   cam_x <= csr_wdata;
               CSR_CAMERA_Y:   cam_y <= csr_wdata;
               CSR_CAMERA_Z:   cam_z <= csr_wdata;
               CSR_COS_YAW:    cyaw <= csr_wdata[15:0];
               CSR_SIN_YAW:    syaw <= csr_wdata[15:0];
               CSR_COS_PITCH:  cpitch <= csr_wdata[15:0];
               CSR_SIN_PITCH:  spitch <= csr_wdata[15:0];
               CSR_PROJ_SCALE: pscale <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) pixel_queue.push_back(project_segment(req_tdata));
         // compare each result with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[64:0];
            if (pixel_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               want = pixel_queue.pop_front();
               if (got !== want || rsp_tdata[71:65] !== '0) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch vis %0b/%0b s(%0d,%0d)/(%0d,%0d) e(%0d,%0d)/(%0d,%0d)",
                        want.visible, got.visible, want.start_sx, want.start_sy,
                        got.start_sx, got.start_sy, want.end_sx, want.end_sy,
                        got.end_sx, got.end_sy);
               end
            end
         end
         pending <= pixel_queue.size();
      end
   end

endmodule

/* sim/tb_segment_near_far_clip_project_unit.sv */
module tb_segment_near_far_clip_project_unit;
   import snfcp_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    fail_count;
   int                    pending;
   logic                  drain_busy = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   segment_near_far_clip_project_unit u_top (.*);

   segment_clip_checker u_checker (.*);

   function automatic int gap_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, 2);
      return $urandom_range(3, 30);
   endfunction

   // receiver stalls; some stretches run without any
   always @(posedge clock) begin
      if (drain_busy) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 99) < 70);
   end

   task automatic write_reg(csr_idx_type idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // hold the request until taken; drop valid only when a gap follows
   task automatic send_segment(logic [REQ_DATA_W-1:0] d, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [31:0] world_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
         default: return 32'($signed($urandom_range(0, 60 << 16)) - (30 << 16));
      endcase
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_segment();
      int mode;
      mode = $urandom_range(0, 99) < 15 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
      return {world_coord(mode), world_coord(mode), world_coord(mode),
              world_coord(mode), world_coord(mode), world_coord(mode)};
   endfunction

   function automatic logic [15:0] trig_value();
      case ($urandom_range(0, 4))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   task automatic random_settings();
      write_reg(CSR_CAMERA_X, 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16)));
      write_reg(CSR_CAMERA_Y, 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16)));
      write_reg(CSR_CAMERA_Z, 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16)));
      write_reg(CSR_COS_YAW, trig_value());
      write_reg(CSR_SIN_YAW, trig_value());
      write_reg(CSR_COS_PITCH, trig_value());
      write_reg(CSR_SIN_PITCH, trig_value());
      write_reg(CSR_PROJ_SCALE, $urandom_range(0, 1) ? $urandom_range(0, 65535) : 4096);
   endtask

   initial begin
      #2000000;
      $display("tb_segment_near_far_clip_project_unit: FAIL");
      $finish;
   end

   initial begin
      logic [31:0] zmin, zmax;
      zmin = 32'h8000_0000;
      zmax = 32'h7fff_ffff;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, plane hits, crossings, rejections (camera at z = -10)
      send_segment({6{32'h0}}, 0);
      send_segment({6{32'hffff_ffff}}, 0);
      send_segment({6{zmax}}, 0);
      send_segment({6{zmin}}, 0);
      send_segment({zmax, zmin, zmax, zmin, zmax, zmin}, 0);
      send_segment({zmin, zmax, zmin, zmax, zmin, zmax}, 1);
      // both behind the camera, both beyond far
      send_segment({-32'sd1310720, 64'h0, -32'sd1310720, 64'h0}, 0);
      send_segment({32'sd40000000, 64'h0, 32'sd40000000, 64'h0}, 0);
      // ends exactly on the near plane, and on the far plane
      send_segment({-32'sd642253, 64'h0, -32'sd642253, 64'h0}, 0);
      send_segment({32'sd32112640, 64'h0, -32'sd642253, 64'h0}, 0);
      // crossing near, crossing far, crossing both in each direction
      send_segment({32'sd655360, 64'h10000, -32'sd1310720, 32'h0, 32'hfff0_0000}, 0);
      send_segment({-32'sd1310720, 64'h10000, 32'sd655360, 32'h0, 32'hfff0_0000}, 0);
      send_segment({32'sd40000000, 32'h0, 32'h50000, 32'sd655360, 64'h0}, 0);
      send_segment({32'sd40000000, 64'h30000, -32'sd9000000, 64'h20000}, 0);
      send_segment({-32'sd9000000, 64'h30000, 32'sd40000000, 64'h20000}, 0);
      wait_quiet();

      // directed: extreme settings
      write_reg(CSR_PROJ_SCALE, 16'hffff);
      write_reg(CSR_COS_YAW, -16'sd16384);
      write_reg(CSR_SIN_PITCH, 16'sd16384);
      write_reg(CSR_COS_PITCH, 16'sd0);
      write_reg(CSR_CAMERA_X, zmin);
      write_reg(CSR_CAMERA_Y, zmax);
      write_reg(CSR_CAMERA_Z, zmax);
      write_reg(CSR_SIN_YAW, 16'sd16384);
      send_segment({6{zmin}}, 0);
      send_segment({6{zmax}}, 0);
      send_segment(random_segment(), 0);
      wait_quiet();
      write_reg(CSR_PROJ_SCALE, 16'h0);
      write_reg(CSR_CAMERA_X, 32'h0);
      write_reg(CSR_CAMERA_Y, 32'h0);
      write_reg(CSR_CAMERA_Z, 32'h0);
      write_reg(CSR_SIN_YAW, 16'sd0);
      write_reg(CSR_COS_YAW, 16'sd16384);
      send_segment({32'sd655360, 64'h0, 32'sd655360, 64'h0}, 0);
      send_segment(random_segment(), 0);
      wait_quiet();

      // random phases, each under new settings
      for (int phase = 0; phase < 8; phase++) begin
         random_settings();
         drain_busy <= (phase % 3 == 2);
         for (int i = 0; i < 200; i++)
            send_segment(random_segment(), (phase % 3 == 2) ? 0 : gap_length());
         wait_quiet();
      end
      drain_busy <= 1'b1;
      wait_quiet();

      if (fail_count == 0) $display("tb_segment_near_far_clip_project_unit: PASS");
      else $display("tb_segment_near_far_clip_project_unit: FAIL");
      $finish;
   end

endmodule
